### rtl/core/abr_pkg.sv
// Shared types, codes and field widths for the branch resolve block.
// No dependencies; every module of the block imports this package.
package abr_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned S_DATA_W = 168;   // 165 payload bits padded to bytes
    localparam int unsigned S_USER_W = 4;
    localparam int unsigned M_DATA_W = 40;    // 35 payload bits padded to bytes
    localparam int unsigned M_USER_W = 3;
    localparam logic [ADDR_W-1:0] INSN_BYTES = ADDR_W'(4);

    localparam logic [VALUE_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [VALUE_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_PAL     = 3'd0,
        REQ_JUMP    = 3'd1,
        REQ_CALL    = 3'd2,
        REQ_RETURN  = 3'd3,
        REQ_BR      = 3'd4,
        REQ_CBRANCH = 3'd5,
        REQ_CMOVE   = 3'd6,
        REQ_OTHER   = 3'd7
    } req_type_t;

    typedef enum logic [2:0] {
        CC_LBC = 3'd0,
        CC_EQ  = 3'd1,
        CC_LT  = 3'd2,
        CC_LE  = 3'd3,
        CC_LBS = 3'd4,
        CC_NE  = 3'd5,
        CC_GE  = 3'd6,
        CC_GT  = 3'd7
    } cond_code_t;

    typedef enum logic [2:0] {
        FLOW_OP      = 3'd0,
        FLOW_JUMP    = 3'd1,
        FLOW_CALL    = 3'd2,
        FLOW_RETURN  = 3'd3,
        FLOW_SYSCALL = 3'd4
    } flow_kind_t;

    typedef enum logic [1:0] {
        TK_TAKEN     = 2'd0,
        TK_NOT_TAKEN = 2'd1,
        TK_BACKWARD  = 2'd2,
        TK_FORWARD   = 2'd3
    } taken_kind_t;

    typedef struct packed {
        req_type_t          req_type;
        cond_code_t         cond_code;
        logic [VALUE_W-1:0] test_value;
        logic               test_is_float;
        logic [ADDR_W-1:0]  disp;
        logic               disp_relative;
        logic               base_present;
        logic [ADDR_W-1:0]  base_value;
        logic [ADDR_W-1:0]  pc;
    } in_item_t;

    typedef struct packed {
        flow_kind_t         flow_kind;
        logic               is_conditional;
        taken_kind_t        taken_kind;
        logic [ADDR_W-1:0]  next_pc;
    } out_item_t;

endpackage

### rtl/core/abr_cond_eval.sv
// Condition test on a 64-bit register value, as integer or as T-float bits.
// Depends on abr_pkg for the condition codes and float field masks.
module abr_cond_eval (
    input  abr_pkg::cond_code_t             cond_code,
    input  logic [abr_pkg::VALUE_W-1:0]     test_value,
    input  logic                            test_is_float,
    output logic                            holds
);
    import abr_pkg::*;

    logic is_nan;
    logic is_zero;
    logic is_neg;

    // NaN and both zeros count as zero in the float view
    assign is_nan  = ((test_value & EXP_MASK) == EXP_MASK) && ((test_value & FRAC_MASK) != '0);
    assign is_zero = test_is_float ? (is_nan || ((test_value & MAG_MASK) == '0))
                                   : (test_value == '0);
    assign is_neg  = !is_zero && test_value[VALUE_W-1];

    always_comb
    begin
        unique case (cond_code)
            CC_LBC:  holds = !test_value[0];
            CC_EQ:   holds = is_zero;
            CC_LT:   holds = is_neg;
            CC_LE:   holds = is_neg || is_zero;
            CC_LBS:  holds = test_value[0];
            CC_NE:   holds = !is_zero;
            CC_GE:   holds = !is_neg;
            CC_GT:   holds = !is_neg && !is_zero;
            default: holds = 1'b0;
        endcase
    end

endmodule

### rtl/core/abr_resolve.sv
// Combinational resolve of one instruction word: flow kind, taken kind, next pc.
// Depends on abr_pkg and abr_cond_eval.
module abr_resolve (
    input  abr_pkg::in_item_t   item,
    output abr_pkg::out_item_t  result
);
    import abr_pkg::*;

    logic              holds;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] seq_pc;
    taken_kind_t       dir;

    abr_cond_eval u_cond (
        .cond_code     (item.cond_code),
        .test_value    (item.test_value),
        .test_is_float (item.test_is_float),
        .holds         (holds)
    );

    assign target = item.disp
                  + (item.disp_relative ? item.pc : '0)
                  + (item.base_present ? item.base_value : '0);
    assign seq_pc = item.pc + INSN_BYTES;
    assign dir    = item.disp[ADDR_W-1] ? TK_BACKWARD : TK_FORWARD;

    always_comb
    begin
        result.flow_kind      = FLOW_OP;
        result.is_conditional = 1'b0;
        result.taken_kind     = TK_TAKEN;
        result.next_pc        = seq_pc;
        unique case (item.req_type)
            REQ_PAL:
            begin
                result.flow_kind = FLOW_SYSCALL;
            end
            REQ_JUMP:
            begin
                result.flow_kind = FLOW_JUMP;
                result.next_pc   = target;
            end
            REQ_CALL:
            begin
                result.flow_kind = FLOW_CALL;
                result.next_pc   = target;
            end
            REQ_RETURN:
            begin
                result.flow_kind = FLOW_RETURN;
                result.next_pc   = target;
            end
            REQ_BR:
            begin
                result.flow_kind  = FLOW_JUMP;
                result.taken_kind = dir;
                result.next_pc    = target;
            end
            REQ_CBRANCH:
            begin
                result.flow_kind      = FLOW_JUMP;
                result.is_conditional = 1'b1;
                if (holds)
                begin
                    result.taken_kind = dir;
                    result.next_pc    = target;
                end
                else
                begin
                    result.taken_kind = TK_NOT_TAKEN;
                end
            end
            REQ_CMOVE:
            begin
                result.is_conditional = 1'b1;
                result.taken_kind     = holds ? TK_TAKEN : TK_NOT_TAKEN;
            end
            default:
            begin
                result.flow_kind = FLOW_OP;
            end
        endcase
    end

endmodule

### rtl/core/alpha_branch_resolve.sv
// Top level of the branch resolve block: input register, resolve logic, result register.
// Depends on abr_pkg and abr_resolve.
//
// Usage:
//   One decoded instruction word enters on the s_ channel (tvalid/tready), with
//   the class and the float flag in s_tuser and the operands in s_tdata. One
//   result word leaves on the m_ channel for every word taken, in order, with
//   the flow kind in m_tuser and the condition flag, taken kind and next pc in
//   m_tdata.
//   A taken word goes from the input register to the result register driving m_tvalid.
//   Throughput: one word per cycle while m_tready is high, in a two-stage pipeline.
//   s_tready stays high while the pipeline has room; a full pipeline with m_tready
//   low drops s_tready, and both stages hold their words until m_tready returns.
//   Reset empties both stages; the block holds no other state.
module alpha_branch_resolve (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cond_code[2:0], test_value[66:3], disp[98:67], disp_relative[99],
    // base_present[100], base_value[132:101], pc[164:133], zero pad[167:165]
    input  logic [abr_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[2:0], test_is_float[3]
    input  logic [abr_pkg::S_USER_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // is_conditional[0], taken_kind[2:1], next_pc[34:3], zero pad[39:35]
    output logic [abr_pkg::M_DATA_W-1:0]   m_tdata,
    // flow_kind[2:0]
    output logic [abr_pkg::M_USER_W-1:0]   m_tuser
);
    import abr_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    in_item_t   in_item_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       out_load;
    logic       in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next.req_type      = req_type_t'(s_tuser[2:0]);
        in_item_next.test_is_float = s_tuser[3];
        in_item_next.cond_code     = cond_code_t'(s_tdata[2:0]);
        in_item_next.test_value    = s_tdata[66:3];
        in_item_next.disp          = s_tdata[98:67];
        in_item_next.disp_relative = s_tdata[99];
        in_item_next.base_present  = s_tdata[100];
        in_item_next.base_value    = s_tdata[132:101];
        in_item_next.pc            = s_tdata[164:133];
    end

    abr_resolve u_resolve (
        .item   (in_item_reg),
        .result (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_item_next;
        end
        // advance only a live word so a stalled result is never overwritten
        if (out_load && in_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.flow_kind;
    assign m_tdata  = {5'd0, out_item_reg.next_pc, out_item_reg.taken_kind,
                       out_item_reg.is_conditional};

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input side stalled with an empty result stage");

    a_input_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input stage word lost during result stall");

    a_not_taken_is_cond: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.taken_kind == TK_NOT_TAKEN)
            |-> out_item_reg.is_conditional)
        else $error("not-taken result on an unconditional instruction");

    a_syscall_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.flow_kind == FLOW_SYSCALL)
            |-> (out_item_reg.taken_kind == TK_TAKEN && !out_item_reg.is_conditional))
        else $error("system call result with a conditional taken kind");

endmodule

### tb/testbench.sv
// Self-checking bench for alpha_branch_resolve: directed rows then random instruction words.
// Needs abr_pkg and the alpha_branch_resolve RTL; results are predicted in-bench and compared.
module testbench;
    import abr_pkg::*;

    typedef struct {
        in_item_t  stim;
        bit        typed;   // want holds a hand-written result
        out_item_t want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    out_item_t pending_results[$];
    dir_row_t  directed_rows[$];
    int        error_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_req = 1'b0;

    alpha_branch_resolve uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -1 negative, 0 zero, +1 positive; NaN and both zeros count as zero for floats
    function automatic int value_sign(logic [VALUE_W-1:0] v, bit is_float);
        if (is_float)
        begin
            if ((v & EXP_MASK) == EXP_MASK && (v & FRAC_MASK) != '0)
                return 0;
            if ((v & MAG_MASK) == '0)
                return 0;
            return v[VALUE_W-1] ? -1 : 1;
        end
        if (v[VALUE_W-1])
            return -1;
        return (v != '0) ? 1 : 0;
    endfunction

    function automatic bit cond_met(cond_code_t code, logic [VALUE_W-1:0] v, bit is_float);
        int s;
        s = value_sign(v, is_float);
        case (code)
            CC_LBC:  return !v[0];
            CC_EQ:   return s == 0;
            CC_LT:   return s < 0;
            CC_LE:   return s <= 0;
            CC_LBS:  return v[0];
            CC_NE:   return s != 0;
            CC_GE:   return s >= 0;
            default: return s > 0;
        endcase
    endfunction

    function automatic out_item_t resolve_branch(in_item_t it);
        out_item_t   r;
        logic [31:0] target;
        taken_kind_t dir;
        target = it.disp;
        if (it.disp_relative)
            target = target + it.pc;
        if (it.base_present)
            target = target + it.base_value;
        dir = it.disp[ADDR_W-1] ? TK_BACKWARD : TK_FORWARD;
        r.flow_kind      = FLOW_OP;
        r.is_conditional = 1'b0;
        r.taken_kind     = TK_TAKEN;
        r.next_pc        = it.pc + INSN_BYTES;
        case (it.req_type)
            REQ_PAL:    r.flow_kind = FLOW_SYSCALL;
            REQ_JUMP:
            begin
                r.flow_kind = FLOW_JUMP;
                r.next_pc   = target;
            end
            REQ_CALL:
            begin
                r.flow_kind = FLOW_CALL;
                r.next_pc   = target;
            end
            REQ_RETURN:
            begin
                r.flow_kind = FLOW_RETURN;
                r.next_pc   = target;
            end
            REQ_BR:
            begin
                r.flow_kind  = FLOW_JUMP;
                r.taken_kind = dir;
                r.next_pc    = target;
            end
            REQ_CBRANCH:
            begin
                r.flow_kind      = FLOW_JUMP;
                r.is_conditional = 1'b1;
                if (cond_met(it.cond_code, it.test_value, it.test_is_float))
                begin
                    r.taken_kind = dir;
                    r.next_pc    = target;
                end
                else
                    r.taken_kind = TK_NOT_TAKEN;
            end
            REQ_CMOVE:
            begin
                r.is_conditional = 1'b1;
                r.taken_kind = cond_met(it.cond_code, it.test_value, it.test_is_float)
                             ? TK_TAKEN : TK_NOT_TAKEN;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t mk_insn(req_type_t t, cond_code_t c, logic [63:0] v, bit f,
                                         logic [31:0] d, bit rel, bit bp, logic [31:0] b,
                                         logic [31:0] pc);
        in_item_t it;
        it.req_type      = t;
        it.cond_code     = c;
        it.test_value    = v;
        it.test_is_float = f;
        it.disp          = d;
        it.disp_relative = rel;
        it.base_present  = bp;
        it.base_value    = b;
        it.pc            = pc;
        return it;
    endfunction

    function automatic out_item_t mk_result(flow_kind_t fk, bit c, taken_kind_t tk,
                                            logic [31:0] npc);
        out_item_t r;
        r.flow_kind      = fk;
        r.is_conditional = c;
        r.taken_kind     = tk;
        r.next_pc        = npc;
        return r;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [51:0] frac;
        frac = {20'($urandom_range(0, 32'hF_FFFF)), $urandom};
        if (frac == '0)
            frac = 52'd1;
        case ($urandom_range(0, 7))
            0: v = {1'($urandom_range(0, 1)), 63'd0};                     // +0 / -0
            1: v = {1'($urandom_range(0, 1)), 11'h7FF, frac};             // NaN
            2: v = {1'($urandom_range(0, 1)), 11'h7FF, 52'd0};            // infinity
            3: v = {1'($urandom_range(0, 1)), 11'h000, frac};             // denormal
            4: v = 64'($signed(4'($urandom_range(0, 15))));               // small int
            5: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic in_item_t random_insn();
        in_item_t    it;
        int          pick;
        logic [31:0] d;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            it.req_type = REQ_CBRANCH;
        else if (pick < 5)
            it.req_type = REQ_CMOVE;
        else
            it.req_type = req_type_t'($urandom_range(0, 7));
        it.cond_code     = cond_code_t'($urandom_range(0, 7));
        it.test_value    = random_value();
        it.test_is_float = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: d = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1, 2: d = 32'($signed(12'($urandom_range(0, 4095)))) << 2;
            default: d = $urandom;
        endcase
        it.disp          = d;
        it.disp_relative = 1'($urandom_range(0, 1));
        it.base_present  = 1'($urandom_range(0, 1));
        it.base_value    = $urandom;
        it.pc            = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFC - ($urandom_range(0, 7) << 2)
                                                     : $urandom;
        return it;
    endfunction

    // Offer one word, after a random gap if idle_on, hold it until taken, log its result.
    task automatic send_word(in_item_t it, out_item_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.pc, it.base_value, it.base_present, it.disp_relative,
                     it.disp, it.test_value, it.cond_code};
        s_tuser  <= {it.test_is_float, it.req_type};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(want);
    endtask

    // Result side: random stall per word if idle_on, one long hold when asked.
    initial
    begin
        int stall;
        repeat (5) @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 80;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: m_tdata=%h m_tuser=%h", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[2:0] != want.flow_kind)
                begin
                    $error("flow_kind: expected %0d, got %0d", want.flow_kind, m_tuser[2:0]);
                    error_count++;
                end
                if (m_tdata[0] != want.is_conditional)
                begin
                    $error("is_conditional: expected %0d, got %0d",
                           want.is_conditional, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[2:1] != want.taken_kind)
                begin
                    $error("taken_kind: expected %0d, got %0d", want.taken_kind, m_tdata[2:1]);
                    error_count++;
                end
                if (m_tdata[34:3] != want.next_pc)
                begin
                    $error("next_pc: expected %h, got %h", want.next_pc, m_tdata[34:3]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        in_item_t  it;
        out_item_t want;
        int        n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows.push_back('{mk_insn(REQ_PAL, CC_EQ, 64'd0, 1'b0, 32'd0, 1'b0, 1'b0,
            32'd0, 32'hFFFF_FFFC), 1'b1, mk_result(FLOW_SYSCALL, 1'b0, TK_TAKEN, 32'd0)});
        directed_rows.push_back('{mk_insn(REQ_JUMP, CC_EQ, 64'd0, 1'b0, 32'h1000, 1'b0, 1'b0,
            32'hDEAD_BEEF, 32'h40), 1'b1, mk_result(FLOW_JUMP, 1'b0, TK_TAKEN, 32'h1000)});
        directed_rows.push_back('{mk_insn(REQ_CALL, CC_LT, 64'd5, 1'b0, -32'sd8, 1'b1, 1'b1,
            32'h100, 32'h2000), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_RETURN, CC_GT, '1, 1'b1, 32'd0, 1'b0, 1'b1,
            32'hFFFF_FFFF, 32'h80), 1'b1,
            mk_result(FLOW_RETURN, 1'b0, TK_TAKEN, 32'hFFFF_FFFF)});
        directed_rows.push_back('{mk_insn(REQ_BR, CC_EQ, 64'd1, 1'b0, 32'h8000_0000, 1'b1, 1'b0,
            32'd0, 32'd0), 1'b1, mk_result(FLOW_JUMP, 1'b0, TK_BACKWARD, 32'h8000_0000)});
        directed_rows.push_back('{mk_insn(REQ_BR, CC_EQ, 64'd1, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0,
            32'd0, 32'd1), 1'b1, mk_result(FLOW_JUMP, 1'b0, TK_FORWARD, 32'h8000_0000)});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_EQ, 64'd0, 1'b0, 32'h20, 1'b1, 1'b0,
            32'd0, 32'h1000), 1'b0, want});
        // negative zero, NaN, infinities and denormals as floats
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_EQ, 64'h8000_0000_0000_0000, 1'b1,
            -32'sd16, 1'b1, 1'b0, 32'd0, 32'h1000), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_EQ, 64'h7FF0_0000_0000_0001, 1'b1,
            32'h40, 1'b1, 1'b0, 32'd0, 32'h1000), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_LT, 64'hFFF0_0000_0000_0000, 1'b1,
            -32'sd4, 1'b1, 1'b1, 32'h10, 32'h1000), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_GT, 64'h7FF0_0000_0000_0000, 1'b1,
            32'h8, 1'b1, 1'b0, 32'd0, 32'h3000), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_LT, 64'h8000_0000_0000_0001, 1'b1,
            32'h8, 1'b1, 1'b0, 32'd0, 32'h3000), 1'b0, want});
        // low-bit tests read the raw bits even for a float register
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_LBC, 64'h7FF0_0000_0000_0001, 1'b1,
            32'h40, 1'b1, 1'b0, 32'd0, 32'h100), 1'b1,
            mk_result(FLOW_JUMP, 1'b1, TK_NOT_TAKEN, 32'h104)});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_LBS, '1, 1'b1, 32'h40, 1'b1, 1'b0,
            32'd0, 32'h100), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_LE, 64'h8000_0000_0000_0000, 1'b0,
            32'h40, 1'b0, 1'b1, 32'h5000, 32'h100), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_NE, 64'd0, 1'b0, 32'h40, 1'b1, 1'b0,
            32'd0, 32'h100), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_GE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0,
            -32'sd64, 1'b1, 1'b0, 32'd0, 32'h100), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CBRANCH, CC_GT, '1, 1'b0, 32'h40, 1'b1, 1'b0,
            32'd0, 32'h100), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CMOVE, CC_GE, 64'hFFF8_0000_0000_0000, 1'b1,
            32'd0, 1'b0, 1'b0, 32'd0, 32'h200), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CMOVE, CC_GT, 64'd0, 1'b0, 32'd0, 1'b0, 1'b0,
            32'd0, 32'h200), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CMOVE, CC_LBS, 64'd1, 1'b0, 32'd0, 1'b0, 1'b0,
            32'd0, 32'h200), 1'b0, want});
        directed_rows.push_back('{mk_insn(REQ_CMOVE, CC_LT, 64'd0, 1'b1, 32'd0, 1'b0, 1'b0,
            32'd0, 32'h200), 1'b0, want});
        // condition code and value are don't-care outside the conditional classes
        directed_rows.push_back('{mk_insn(REQ_OTHER, CC_LBS, 64'd1, 1'b1, 32'h8000_0000, 1'b1,
            1'b1, 32'h1234, 32'h300), 1'b1, mk_result(FLOW_OP, 1'b0, TK_TAKEN, 32'h304)});
        directed_rows.push_back('{mk_insn(REQ_JUMP, CC_EQ, 64'd0, 1'b0, 32'hFFFF_FFFF, 1'b1,
            1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, want});

        foreach (directed_rows[i])
            send_word(directed_rows[i].stim, directed_rows[i].typed ? directed_rows[i].want
                                                                    : resolve_branch(
                                                                      directed_rows[i].stim));

        for (n = 0; n < 1800; n++)
        begin
            // back-to-back stretch in the middle, with one long result-side hold
            idle_on = !(n >= 600 && n < 1000);
            if (n == 700)
                hold_req = 1'b1;
            it = random_insn();
            send_word(it, resolve_branch(it));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/abr_pkg.sv
rtl/core/abr_cond_eval.sv
rtl/core/abr_resolve.sv
rtl/core/alpha_branch_resolve.sv
tb/testbench.sv
